/* rtl/fsc_pkg.sv */
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int LOG_BITS   = 20;
    localparam int FRAC_BITS  = 10;
    localparam int CODONS     = 64;
    localparam int CODON_BITS = 6;
    localparam int LSE_STEPS  = 64;
    localparam int LSE_SHIFT  = FRAC_BITS - 3;
    localparam int Q_SHIFT    = 16 - FRAC_BITS;
    localparam int PC_BITS    = 7;
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = 1;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [LOG_BITS-1:0] lval_t;

    localparam lval_t NEG_INF  = {1'b1, {(LOG_BITS-1){1'b0}}};
    localparam lval_t MAX_CODE = {1'b0, {(LOG_BITS-1){1'b1}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_EPS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EPSC = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUC0 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUC1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUC2 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUC3 = 3'd5;

    localparam lval_t EPS_RESET  = -20'sd4716;
    localparam lval_t EPSC_RESET = -20'sd10;
    localparam lval_t NUC_RESET  = -20'sd1420;

    // Input modes and queued item kinds.
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SCORE  = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] K_WRITE  = 2'd0;
    localparam logic [1:0] K_SCORE  = 2'd1;
    localparam logic [1:0] K_DECODE = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  len_ok;
        logic [2:0]            frag_len;
        logic [4:0][1:0]       z;
        logic [CODON_BITS-1:0] codon;
        lval_t                 table_value;
    } item_t;

    // Micro-operations of the shared log-domain unit.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_LSE = 1'b1;

    localparam logic [3:0] D_E2   = 4'd0;
    localparam logic [3:0] D_F2   = 4'd1;
    localparam logic [3:0] D_E3   = 4'd2;
    localparam logic [3:0] D_F3   = 4'd3;
    localparam logic [3:0] D_C1   = 4'd4;
    localparam logic [3:0] D_C2   = 4'd5;
    localparam logic [3:0] D_C3   = 4'd6;
    localparam logic [3:0] D_T    = 4'd7;
    localparam logic [3:0] D_ACC  = 4'd8;
    localparam logic [3:0] D_ACC2 = 4'd9;

    localparam logic [4:0] S_E     = 5'd0;
    localparam logic [4:0] S_F     = 5'd1;
    localparam logic [4:0] S_E2    = 5'd2;
    localparam logic [4:0] S_F2    = 5'd3;
    localparam logic [4:0] S_E3    = 5'd4;
    localparam logic [4:0] S_F3    = 5'd5;
    localparam logic [4:0] S_C1    = 5'd6;
    localparam logic [4:0] S_C2    = 5'd7;
    localparam logic [4:0] S_C3    = 5'd8;
    localparam logic [4:0] S_T     = 5'd9;
    localparam logic [4:0] S_ACC   = 5'd10;
    localparam logic [4:0] S_ACC2  = 5'd11;
    localparam logic [4:0] S_MARG  = 5'd12;
    localparam logic [4:0] S_LN2   = 5'd13;
    localparam logic [4:0] S_LN4   = 5'd14;
    localparam logic [4:0] S_NLN2  = 5'd15;
    localparam logic [4:0] S_NLN3  = 5'd16;
    localparam logic [4:0] S_NLN9  = 5'd17;
    localparam logic [4:0] S_NLN10 = 5'd18;
    localparam logic [4:0] S_NEGI  = 5'd19;
    localparam logic [4:0] S_PA    = 5'd20;
    localparam logic [4:0] S_PB    = 5'd21;
    localparam logic [4:0] S_LC    = 5'd22;

    // Match-count kinds feeding the log-count operand.
    localparam logic [1:0] LC_ANY  = 2'd0;
    localparam logic [1:0] LC_PAIR = 2'd1;
    localparam logic [1:0] LC_TRIP = 2'd2;
    localparam logic [1:0] LC_DUO  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [3:0] dst;
        logic [4:0] a;
        logic [4:0] b;
        logic [2:0] pa;
        logic [2:0] pb;
        logic [1:0] lck;
        logic [2:0] z0;
        logic [2:0] z1;
        logic [2:0] z2;
        logic [1:0] xa;
        logic [1:0] xb;
    } uop_t;

    typedef struct packed {
        lval_t                 e;
        lval_t                 f;
        lval_t                 e2;
        lval_t                 f2;
        lval_t                 e3;
        lval_t                 f3;
        lval_t                 c1;
        lval_t                 c2;
        lval_t                 c3;
        lval_t                 t;
        lval_t                 acc;
        lval_t                 acc2;
        lval_t                 marg;
        lval_t [3:0]           nuc;
        logic [4:0][1:0]       z;
        logic [CODON_BITS-1:0] codon;
    } alu_opnd_t;

    function automatic int reduce_q16(input int k);
        if (Q_SHIFT <= 0) begin
            return k;
        end
        return (k + (1 << (Q_SHIFT - 1))) >>> Q_SHIFT;
    endfunction

    localparam lval_t LN2   = lval_t'(reduce_q16(45426));
    localparam lval_t LN3   = lval_t'(reduce_q16(71999));
    localparam lval_t LN4   = lval_t'(reduce_q16(90852));
    localparam lval_t NLN2  = lval_t'(-reduce_q16(45426));
    localparam lval_t NLN3  = lval_t'(-reduce_q16(71999));
    localparam lval_t NLN9  = lval_t'(-reduce_q16(143997));
    localparam lval_t NLN10 = lval_t'(-reduce_q16(150902));

    localparam int LSE_Q16 [LSE_STEPS] = '{
        45426, 41458, 37745, 34283, 31069, 28095, 25354, 22836,
        20530, 18425, 16510, 14773, 13200, 11780, 10501, 9350,
        8318, 7394, 6567, 5829, 5170, 4583, 4061, 3597,
        3184, 2818, 2493, 2205, 1950, 1724, 1523, 1346,
        1189, 1051, 928, 820, 724, 639, 565, 498,
        440, 389, 343, 303, 267, 236, 208, 184,
        162, 143, 126, 112, 98, 87, 77, 68,
        60, 53, 47, 41, 36, 32, 28, 25};

    function automatic lval_t lse_tab(input logic [5:0] k);
        return lval_t'(reduce_q16(LSE_Q16[k]));
    endfunction

    function automatic uop_t op2(input logic op, input logic [3:0] dst,
                                 input logic [4:0] a, input logic [4:0] b);
        uop_t u;
        u     = '0;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    function automatic uop_t with_lc(input uop_t ui, input logic [1:0] kind,
                                     input int z0, input int z1, input int z2,
                                     input int xa, input int xb);
        uop_t u;
        u     = ui;
        u.lck = kind;
        u.z0  = 3'(z0);
        u.z1  = 3'(z1);
        u.z2  = 3'(z2);
        u.xa  = 2'(xa);
        u.xb  = 2'(xb);
        return u;
    endfunction

    function automatic uop_t with_p(input uop_t ui, input int pa, input int pb);
        uop_t u;
        u    = ui;
        u.pa = 3'(pa);
        u.pb = 3'(pb);
        return u;
    endfunction

    function automatic logic [PC_BITS-1:0] pro_last(input logic [2:0] len);
        case (len)
            3'd1:    return 7'd4;
            3'd2:    return 7'd8;
            3'd3:    return 7'd9;
            3'd4:    return 7'd7;
            default: return 7'd5;
        endcase
    endfunction

    function automatic logic [PC_BITS-1:0] body_last(input logic [2:0] len);
        case (len)
            3'd1:    return 7'd2;
            3'd2:    return 7'd7;
            3'd3:    return 7'd22;
            3'd4:    return 7'd65;
            default: return 7'd31;
        endcase
    endfunction

    // Per-item constants: error powers first, then the length-specific factors.
    function automatic uop_t pro_uop(input logic [2:0] len, input logic [PC_BITS-1:0] pc);
        uop_t u;
        u = '0;
        case (pc)
            7'd0: u = op2(OP_ADD, D_E2, S_E, S_E);
            7'd1: u = op2(OP_ADD, D_F2, S_F, S_F);
            7'd2: u = op2(OP_ADD, D_E3, S_E2, S_E);
            7'd3: u = op2(OP_ADD, D_F3, S_F2, S_F);
            default: begin
                case (len)
                    3'd1: begin
                        if (pc == 7'd4) u = op2(OP_ADD, D_C1, S_E2, S_F2);
                    end
                    3'd2: begin
                        case (pc)
                            7'd4:    u = op2(OP_ADD, D_C1, S_LN2, S_E);
                            7'd5:    u = op2(OP_ADD, D_C1, S_C1, S_F3);
                            7'd6:    u = op2(OP_ADD, D_C1, S_C1, S_NLN3);
                            7'd7:    u = op2(OP_ADD, D_C2, S_E3, S_F);
                            default: u = op2(OP_ADD, D_C2, S_C2, S_NLN3);
                        endcase
                    end
                    3'd3: begin
                        case (pc)
                            7'd4:    u = op2(OP_ADD, D_C1, S_LN4, S_E2);
                            7'd5:    u = op2(OP_ADD, D_C1, S_C1, S_F2);
                            7'd6:    u = op2(OP_ADD, D_C1, S_C1, S_NLN9);
                            7'd7:    u = op2(OP_ADD, D_C2, S_E2, S_E2);
                            7'd8:    u = op2(OP_ADD, D_C2, S_C2, S_NLN9);
                            default: u = op2(OP_ADD, D_C3, S_F2, S_F2);
                        endcase
                    end
                    3'd4: begin
                        case (pc)
                            7'd4:    u = op2(OP_ADD, D_C1, S_E, S_F3);
                            7'd5:    u = op2(OP_ADD, D_C1, S_C1, S_NLN2);
                            7'd6:    u = op2(OP_ADD, D_C2, S_E3, S_F);
                            default: u = op2(OP_ADD, D_C2, S_C2, S_NLN9);
                        endcase
                    end
                    default: begin
                        if (pc == 7'd4) u = op2(OP_ADD, D_C1, S_E2, S_F2);
                        else u = op2(OP_ADD, D_C1, S_C1, S_NLN10);
                    end
                endcase
            end
        endcase
        return u;
    endfunction

    // Per-candidate programme; the last step always adds the codon marginal.
    function automatic uop_t body_uop(input logic [2:0] len, input logic [PC_BITS-1:0] pc);
        uop_t u;
        int   n;
        int   r0;
        int   r1;
        int   r2;
        int   k;
        int   pa;
        int   pb;
        int   first;
        u = '0;
        n = 0;
        case (len)
            3'd1: begin
                case (pc)
                    7'd0: u = with_lc(op2(OP_ADD, D_T, S_C1, S_LC), LC_ANY, 0, 0, 0, 0, 0);
                    7'd1: u = op2(OP_ADD, D_ACC, S_T, S_NLN3);
                    default: u = op2(OP_ADD, D_ACC, S_ACC, S_MARG);
                endcase
            end
            3'd2: begin
                case (pc)
                    7'd0: u = with_lc(op2(OP_ADD, D_ACC, S_C1, S_LC), LC_PAIR, 0, 1, 0, 0, 0);
                    7'd1: u = with_lc(op2(OP_ADD, D_T, S_C2, S_LC), LC_ANY, 0, 0, 0, 0, 0);
                    7'd2: u = with_p(op2(OP_ADD, D_T, S_T, S_PA), 1, 0);
                    7'd3: u = op2(OP_LSE, D_ACC, S_ACC, S_T);
                    7'd4: u = with_lc(op2(OP_ADD, D_T, S_C2, S_LC), LC_ANY, 1, 0, 0, 0, 0);
                    7'd5: u = with_p(op2(OP_ADD, D_T, S_T, S_PA), 0, 0);
                    7'd6: u = op2(OP_LSE, D_ACC, S_ACC, S_T);
                    default: u = op2(OP_ADD, D_ACC, S_ACC, S_MARG);
                endcase
            end
            3'd3: begin
                if (pc == 7'(n)) begin
                    u = with_lc(op2(OP_ADD, D_ACC, S_C3, S_LC), LC_TRIP, 0, 1, 2, 0, 0);
                end
                n++;
                for (int j = 0; j < 3; j++) begin
                    r0 = (j == 0) ? 1 : 0;
                    r1 = (j == 2) ? 1 : 2;
                    if (pc == 7'(n)) begin
                        u = with_lc(op2(OP_ADD, D_T, S_C1, S_LC), LC_PAIR, r0, r1, 0, 0, 0);
                    end
                    n++;
                    if (pc == 7'(n)) u = with_p(op2(OP_ADD, D_T, S_T, S_PA), j, 0);
                    n++;
                    if (pc == 7'(n)) u = op2(OP_LSE, D_ACC, S_ACC, S_T);
                    n++;
                end
                for (int j = 0; j < 3; j++) begin
                    r0 = 2 - j;
                    pa = (j == 2) ? 1 : 0;
                    pb = (j == 0) ? 1 : 2;
                    if (pc == 7'(n)) begin
                        u = with_lc(op2(OP_ADD, D_T, S_C2, S_LC), LC_ANY, r0, 0, 0, 0, 0);
                    end
                    n++;
                    if (pc == 7'(n)) u = with_p(op2(OP_ADD, D_T, S_T, S_PA), pa, 0);
                    n++;
                    if (pc == 7'(n)) u = with_p(op2(OP_ADD, D_T, S_T, S_PA), pb, 0);
                    n++;
                    if (pc == 7'(n)) u = op2(OP_LSE, D_ACC, S_ACC, S_T);
                    n++;
                end
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC, S_ACC, S_MARG);
            end
            3'd4: begin
                for (int j = 0; j < 4; j++) begin
                    r0 = (j == 0) ? 1 : 0;
                    r1 = (j <= 1) ? 2 : 1;
                    r2 = (j <= 2) ? 3 : 2;
                    if (pc == 7'(n)) begin
                        u = with_p(with_lc(op2(OP_ADD, D_T, S_LC, S_PA),
                                           LC_TRIP, r0, r1, r2, 0, 0), j, 0);
                    end
                    n++;
                    if (pc == 7'(n)) begin
                        u = op2(OP_LSE, D_ACC, (j == 0) ? S_NEGI : S_ACC, S_T);
                    end
                    n++;
                end
                first = 1;
                for (int s = 0; s < 3; s++) begin
                    pa = (s == 0) ? 1 : 0;
                    pb = (s == 2) ? 1 : 2;
                    for (int d1 = 0; d1 < 4; d1++) begin
                        for (int d2 = 0; d2 < 4; d2++) begin
                            if (d2 > d1) begin
                                k  = 0;
                                r0 = 0;
                                r1 = 0;
                                for (int i = 0; i < 4; i++) begin
                                    if (i != d1 && i != d2) begin
                                        if (k == 0) r0 = i;
                                        else r1 = i;
                                        k++;
                                    end
                                end
                                if (pc == 7'(n)) begin
                                    u = with_p(with_lc(op2(OP_ADD, D_T, S_LC, S_PA),
                                                       LC_DUO, r0, r1, 0, pa, pb), d1, 0);
                                end
                                n++;
                                if (pc == 7'(n)) u = with_p(op2(OP_ADD, D_T, S_T, S_PA), d2, 0);
                                n++;
                                if (pc == 7'(n)) begin
                                    u = op2(OP_LSE, D_ACC2, (first != 0) ? S_NEGI : S_ACC2, S_T);
                                end
                                n++;
                                first = 0;
                            end
                        end
                    end
                end
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC, S_C1, S_ACC);
                n++;
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC2, S_C2, S_ACC2);
                n++;
                if (pc == 7'(n)) u = op2(OP_LSE, D_ACC, S_ACC, S_ACC2);
                n++;
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC, S_ACC, S_MARG);
            end
            default: begin
                first = 1;
                for (int d1 = 0; d1 < 5; d1++) begin
                    for (int d2 = 0; d2 < 5; d2++) begin
                        if (d2 > d1) begin
                            k  = 0;
                            r0 = 0;
                            r1 = 0;
                            r2 = 0;
                            for (int i = 0; i < 5; i++) begin
                                if (i != d1 && i != d2) begin
                                    if (k == 0) r0 = i;
                                    else if (k == 1) r1 = i;
                                    else r2 = i;
                                    k++;
                                end
                            end
                            if (pc == 7'(n)) u = with_p(op2(OP_ADD, D_T, S_PA, S_PB), d1, d2);
                            n++;
                            if (pc == 7'(n)) begin
                                u = with_lc(op2(OP_ADD, D_T, S_T, S_LC), LC_TRIP, r0, r1, r2, 0, 0);
                            end
                            n++;
                            if (pc == 7'(n)) begin
                                u = op2(OP_LSE, D_ACC, (first != 0) ? S_NEGI : S_ACC, S_T);
                            end
                            n++;
                            first = 0;
                        end
                    end
                end
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC, S_C1, S_ACC);
                n++;
                if (pc == 7'(n)) u = op2(OP_ADD, D_ACC, S_ACC, S_MARG);
            end
        endcase
        return u;
    endfunction

endpackage

/* rtl/fsc_ram.sv */
`timescale 1ns / 1ps

module fsc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/fsc_front.sv */
`timescale 1ns / 1ps

module fsc_front import fsc_pkg::*; (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [2:0]            s_frag_len,
    input  logic [1:0]            s_sym0,
    input  logic [1:0]            s_sym1,
    input  logic [1:0]            s_sym2,
    input  logic [1:0]            s_sym3,
    input  logic [1:0]            s_sym4,
    input  logic [CODON_BITS-1:0] s_codon_index,
    input  lval_t                 s_table_value,
    output logic                  push_valid,
    input  logic                  push_ready,
    output item_t                 push_item
);

    logic [1:0] kind;

    always_comb begin
        unique case (s_mode)
            MODE_WRITE:  kind = K_WRITE;
            MODE_SCORE:  kind = K_SCORE;
            MODE_DECODE: kind = K_DECODE;
            default:     kind = K_WRITE;
        endcase
    end

    // Unused-mode beats are taken and dropped here.
    assign s_ready    = push_ready;
    assign push_valid = s_valid && (s_mode != MODE_NONE);

    always_comb begin
        push_item.kind        = kind;
        push_item.len_ok      = (s_frag_len >= 3'd1) && (s_frag_len <= 3'd5);
        push_item.frag_len    = s_frag_len;
        push_item.z           = {s_sym4, s_sym3, s_sym2, s_sym1, s_sym0};
        push_item.codon       = s_codon_index;
        push_item.table_value = s_table_value;
    end

endmodule

/* rtl/fsc_fifo.sv */
`timescale 1ns / 1ps

module fsc_fifo import fsc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t                entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign in_ready  = (count_reg != (QPTR_BITS+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/fsc_alu.sv */
`timescale 1ns / 1ps

module fsc_alu import fsc_pkg::*; (
    input  uop_t      uop,
    input  alu_opnd_t opnd,
    output lval_t     result
);

    typedef logic signed [LOG_BITS:0] wide_t;

    localparam wide_t W_NEG = {1'b1, NEG_INF};
    localparam wide_t W_MAX = {1'b0, MAX_CODE};

    function automatic lval_t sat(input wide_t x);
        if (x <= W_NEG) return NEG_INF;
        if (x > W_MAX) return MAX_CODE;
        return x[LOG_BITS-1:0];
    endfunction

    function automatic lval_t ladd(input lval_t a, input lval_t b);
        wide_t s;
        s = wide_t'({a[LOG_BITS-1], a}) + wide_t'({b[LOG_BITS-1], b});
        if (a == NEG_INF || b == NEG_INF) return NEG_INF;
        return sat(s);
    endfunction

    function automatic lval_t lse(input lval_t a, input lval_t b);
        wide_t             wa;
        wide_t             wb;
        wide_t             m;
        logic [LOG_BITS:0] d;
        wa = {a[LOG_BITS-1], a};
        wb = {b[LOG_BITS-1], b};
        if (a == NEG_INF) return b;
        if (b == NEG_INF) return a;
        if (wa > wb) begin
            m = wa;
            d = wa - wb;
        end else begin
            m = wb;
            d = wb - wa;
        end
        if ((d >> LSE_SHIFT) < LSE_STEPS) begin
            return sat(m + wide_t'({1'b0, lse_tab(d[LSE_SHIFT +: 6])}));
        end
        return m[LOG_BITS-1:0];
    endfunction

    function automatic logic [1:0] zsym(input logic [4:0][1:0] z, input logic [2:0] i);
        case (i)
            3'd0:    return z[0];
            3'd1:    return z[1];
            3'd2:    return z[2];
            3'd3:    return z[3];
            default: return z[4];
        endcase
    endfunction

    logic [1:0] x0;
    logic [1:0] x1;
    logic [1:0] x2;
    logic [1:0] xa_sym;
    logic [1:0] xb_sym;
    logic [1:0] zu;
    logic [1:0] zw;
    logic [1:0] zv;
    logic [1:0] cnt;
    lval_t      lc_val;
    lval_t      pa_val;
    lval_t      pb_val;
    lval_t      opa;
    lval_t      opb;

    assign x0 = opnd.codon[5:4];
    assign x1 = opnd.codon[3:2];
    assign x2 = opnd.codon[1:0];
    assign zu = zsym(opnd.z, uop.z0);
    assign zw = zsym(opnd.z, uop.z1);
    assign zv = zsym(opnd.z, uop.z2);
    assign xa_sym = (uop.xa == 2'd0) ? x0 : ((uop.xa == 2'd1) ? x1 : x2);
    assign xb_sym = (uop.xb == 2'd0) ? x0 : ((uop.xb == 2'd1) ? x1 : x2);
    assign pa_val = opnd.nuc[zsym(opnd.z, uop.pa)];
    assign pb_val = opnd.nuc[zsym(opnd.z, uop.pb)];

    always_comb begin
        unique case (uop.lck)
            LC_ANY: begin
                cnt = {1'b0, x0 == zu} + {1'b0, x1 == zu} + {1'b0, x2 == zu};
            end
            LC_PAIR: begin
                cnt = {1'b0, (x1 == zu) && (x2 == zw)} + {1'b0, (x0 == zu) && (x2 == zw)}
                    + {1'b0, (x0 == zu) && (x1 == zw)};
            end
            LC_TRIP: begin
                cnt = {1'b0, (x0 == zu) && (x1 == zw) && (x2 == zv)};
            end
            default: begin
                cnt = {1'b0, (xa_sym == zu) && (xb_sym == zw)};
            end
        endcase
        unique case (cnt)
            2'd0:    lc_val = NEG_INF;
            2'd1:    lc_val = '0;
            2'd2:    lc_val = LN2;
            default: lc_val = LN3;
        endcase
    end

    function automatic lval_t pick(input logic [4:0] s, input alu_opnd_t o,
                                   input lval_t lc, input lval_t pa, input lval_t pb);
        case (s)
            S_E:     return o.e;
            S_F:     return o.f;
            S_E2:    return o.e2;
            S_F2:    return o.f2;
            S_E3:    return o.e3;
            S_F3:    return o.f3;
            S_C1:    return o.c1;
            S_C2:    return o.c2;
            S_C3:    return o.c3;
            S_T:     return o.t;
            S_ACC:   return o.acc;
            S_ACC2:  return o.acc2;
            S_MARG:  return o.marg;
            S_LN2:   return LN2;
            S_LN4:   return LN4;
            S_NLN2:  return NLN2;
            S_NLN3:  return NLN3;
            S_NLN9:  return NLN9;
            S_NLN10: return NLN10;
            S_NEGI:  return NEG_INF;
            S_PA:    return pa;
            S_PB:    return pb;
            S_LC:    return lc;
            default: return '0;
        endcase
    endfunction

    assign opa    = pick(uop.a, opnd, lc_val, pa_val, pb_val);
    assign opb    = pick(uop.b, opnd, lc_val, pa_val, pb_val);
    assign result = (uop.op == OP_LSE) ? lse(opa, opb) : ladd(opa, opb);

endmodule

/* rtl/fsc_back.sv */
`timescale 1ns / 1ps

module fsc_back import fsc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  lval_t                   cfg_wdata,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  item_t                   q_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lval_t                   m_score,
    output logic [CODON_BITS-1:0]   m_best_codon,
    output logic                    m_invalid
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRO  = 3'd1;
    localparam logic [2:0] ST_BODY = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]            state_reg;
    logic [PC_BITS-1:0]    pc_reg;
    logic [1:0]            kind_reg;
    logic [2:0]            len_reg;
    logic [4:0][1:0]       z_reg;
    logic [CODON_BITS-1:0] cand_reg;
    lval_t                 best_score_reg;
    logic [CODON_BITS-1:0] best_idx_reg;
    lval_t                 score_reg;
    logic [CODON_BITS-1:0] codon_out_reg;
    logic                  invalid_reg;

    lval_t                 eps_reg;
    lval_t                 epsc_reg;
    lval_t [3:0]           nuc_reg;

    lval_t e2_reg, f2_reg, e3_reg, f3_reg;
    lval_t c1_reg, c2_reg, c3_reg, t_reg, acc_reg, acc2_reg;

    lval_t     marg;
    uop_t      uop;
    alu_opnd_t opnd;
    lval_t     alu_res;
    logic      take;
    logic      alu_wr;
    logic      better;
    lval_t     best_score_next;
    logic [CODON_BITS-1:0] best_idx_next;

    assign take    = q_valid && (state_reg == ST_IDLE);
    assign q_ready = (state_reg == ST_IDLE);
    assign alu_wr  = (state_reg == ST_PRO) || (state_reg == ST_BODY);

    fsc_ram #(
        .WIDTH (LOG_BITS),
        .DEPTH (CODONS)
    ) u_marg_ram (
        .aclk    (aclk),
        .wr_en   (take && (q_item.kind == K_WRITE)),
        .wr_addr (q_item.codon),
        .wr_data (q_item.table_value),
        .rd_addr (cand_reg),
        .rd_data (marg)
    );

    always_comb begin
        if (state_reg == ST_PRO) begin
            uop = pro_uop(len_reg, pc_reg);
        end else begin
            uop = body_uop(len_reg, pc_reg);
        end
    end

    always_comb begin
        opnd.e     = eps_reg;
        opnd.f     = epsc_reg;
        opnd.e2    = e2_reg;
        opnd.f2    = f2_reg;
        opnd.e3    = e3_reg;
        opnd.f3    = f3_reg;
        opnd.c1    = c1_reg;
        opnd.c2    = c2_reg;
        opnd.c3    = c3_reg;
        opnd.t     = t_reg;
        opnd.acc   = acc_reg;
        opnd.acc2  = acc2_reg;
        opnd.marg  = marg;
        opnd.nuc   = nuc_reg;
        opnd.z     = z_reg;
        opnd.codon = cand_reg;
    end

    fsc_alu u_alu (
        .uop    (uop),
        .opnd   (opnd),
        .result (alu_res)
    );

    // Later candidates win ties, so the compare is inclusive.
    assign better          = ($signed(acc_reg) >= $signed(best_score_reg));
    assign best_score_next = better ? acc_reg : best_score_reg;
    assign best_idx_next   = better ? cand_reg : best_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg  <= EPS_RESET;
            epsc_reg <= EPSC_RESET;
            nuc_reg  <= {NUC_RESET, NUC_RESET, NUC_RESET, NUC_RESET};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_EPS:  eps_reg    <= cfg_wdata;
                CFG_EPSC: epsc_reg   <= cfg_wdata;
                CFG_NUC0: nuc_reg[0] <= cfg_wdata;
                CFG_NUC1: nuc_reg[1] <= cfg_wdata;
                CFG_NUC2: nuc_reg[2] <= cfg_wdata;
                CFG_NUC3: nuc_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (alu_wr) begin
            unique case (uop.dst)
                D_E2:    e2_reg   <= alu_res;
                D_F2:    f2_reg   <= alu_res;
                D_E3:    e3_reg   <= alu_res;
                D_F3:    f3_reg   <= alu_res;
                D_C1:    c1_reg   <= alu_res;
                D_C2:    c2_reg   <= alu_res;
                D_C3:    c3_reg   <= alu_res;
                D_T:     t_reg    <= alu_res;
                D_ACC:   acc_reg  <= alu_res;
                D_ACC2:  acc2_reg <= alu_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            kind_reg       <= K_SCORE;
            len_reg        <= 3'd1;
            z_reg          <= '0;
            cand_reg       <= '0;
            best_score_reg <= NEG_INF;
            best_idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (take && (q_item.kind != K_WRITE)) begin
                        kind_reg       <= q_item.kind;
                        len_reg        <= q_item.frag_len;
                        z_reg          <= q_item.z;
                        cand_reg       <= (q_item.kind == K_SCORE) ? q_item.codon : '0;
                        best_score_reg <= NEG_INF;
                        best_idx_reg   <= '0;
                        pc_reg         <= '0;
                        if (q_item.len_ok) begin
                            state_reg <= ST_PRO;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_PRO: begin
                    if (pc_reg == pro_last(len_reg)) begin
                        pc_reg    <= '0;
                        state_reg <= ST_BODY;
                    end else begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                ST_BODY: begin
                    if (pc_reg == body_last(len_reg)) begin
                        state_reg <= ST_CMP;
                    end else begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                ST_CMP: begin
                    pc_reg <= '0;
                    if (kind_reg == K_SCORE) begin
                        state_reg <= ST_OUT;
                    end else begin
                        best_score_reg <= best_score_next;
                        best_idx_reg   <= best_idx_next;
                        if (cand_reg == CODON_BITS'(CODONS - 1)) begin
                            cand_reg  <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            cand_reg  <= cand_reg + 1'b1;
                            state_reg <= ST_BODY;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && take && !q_item.len_ok) begin
            score_reg     <= NEG_INF;
            codon_out_reg <= (q_item.kind == K_SCORE) ? q_item.codon : '0;
            invalid_reg   <= 1'b1;
        end else if (state_reg == ST_CMP) begin
            invalid_reg <= 1'b0;
            if (kind_reg == K_SCORE) begin
                score_reg     <= acc_reg;
                codon_out_reg <= cand_reg;
            end else begin
                score_reg     <= best_score_next;
                codon_out_reg <= best_idx_next;
            end
        end
    end

    assign m_valid      = (state_reg == ST_OUT);
    assign m_score      = score_reg;
    assign m_best_codon = codon_out_reg;
    assign m_invalid    = invalid_reg;

endmodule

/* rtl/frameshift_codon_emission_scorer.sv */
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// s_        s_valid / s_ready        mode, frag_len, sym0..sym4, codon_index, table_value
// m_        m_valid / m_ready        score, best_codon, invalid
// cfg_      cfg_wr_en (no wait)      cfg_index, cfg_wdata
//
// A beat passes a two-entry queue into a sequencer that drives one shared log-add unit,
// one micro-operation per cycle while a programme runs. A table write is done from the idle
// state and a bad length goes straight to the output state; scoring and decode run a setup
// programme, then a per-candidate programme chosen by the length 1 to 5; a decode walks all
// 64 candidates. Reset is synchronous; no clearing pass is needed. The queue keeps taking
// beats while it has room, also while the sequencer works or a result waits for m_ready.

module frameshift_codon_emission_scorer import fsc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  lval_t                   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic [2:0]              s_frag_len,
    input  logic [1:0]              s_sym0,
    input  logic [1:0]              s_sym1,
    input  logic [1:0]              s_sym2,
    input  logic [1:0]              s_sym3,
    input  logic [1:0]              s_sym4,
    input  logic [CODON_BITS-1:0]   s_codon_index,
    input  lval_t                   s_table_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lval_t                   m_score,
    output logic [CODON_BITS-1:0]   m_best_codon,
    output logic                    m_invalid
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    fsc_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_frag_len    (s_frag_len),
        .s_sym0        (s_sym0),
        .s_sym1        (s_sym1),
        .s_sym2        (s_sym2),
        .s_sym3        (s_sym3),
        .s_sym4        (s_sym4),
        .s_codon_index (s_codon_index),
        .s_table_value (s_table_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    fsc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    fsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_score      (m_score),
        .m_best_codon (m_best_codon),
        .m_invalid    (m_invalid)
    );

endmodule
